// File: src/afc_pkg.sv
// Shared types, widths and constants of the altitude complementary filter.
`default_nettype none

package afc_pkg;

    // Shared multiplier operand and product widths
    localparam int OPA_W  = 38;              // widest left operand: rounded velocity gain term
    localparam int OPB_W  = 22;              // widest right operand: 21-bit gain, zero-extended
    localparam int PROD_W = OPA_W + OPB_W;
    localparam int RND_W  = PROD_W - 16;     // product after dropping 16 fraction bits
    localparam int SUM_W  = RND_W + 1;       // one rounded product plus one held term

    // Serial divider: 33-bit magnitude shifted up by 16, padded to an even count
    localparam int DIV_W       = 50;
    localparam int DIV_STEPS   = DIV_W / 2;  // two quotient bits per cycle
    localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

    // Fixed Q16.16 coefficients
    localparam logic signed [OPB_W-1:0] G_Q16      = 22'sd642908;  // 9.81
    localparam logic signed [OPB_W-1:0] W_INERTIAL = 22'sd54067;   // 0.825
    localparam logic signed [OPB_W-1:0] W_BARO     = 22'sd11469;   // 0.175

    // Request kinds carried on tuser
    localparam logic CMD_BARO  = 1'b0;
    localparam logic CMD_ACCEL = 1'b1;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_DECAY_ALPHA    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BARO_GAIN      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_VELOCITY_GAIN  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_VELOCITY_DECAY = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_DEADBAND = 3'd4;

    typedef struct packed {
        logic             start;
        logic             neg;
        logic [DIV_W-1:0] mag;
        logic [15:0]      divisor;
    } afc_div_req_t;

    typedef struct packed {
        logic               done;
        logic signed [31:0] quotient;
    } afc_div_rsp_t;

    // Clamp to signed 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [SUM_W-1:0] v);
        logic in_range;
        in_range = (&v[SUM_W-1:31]) | ~(|v[SUM_W-1:31]);
        if (in_range) begin
            return v[31:0];
        end else if (v[SUM_W-1]) begin
            return 32'sh8000_0000;
        end else begin
            return 32'sh7FFF_FFFF;
        end
    endfunction

endpackage

`default_nettype wire

// File: src/afc_mul.sv
// Shared signed multiplier with registered product and round-to-nearest output.
`default_nettype none

module afc_mul import afc_pkg::*; (
    input  wire logic                    aclk,
    input  wire logic                    en,
    input  wire logic signed [OPA_W-1:0] op_a,
    input  wire logic signed [OPB_W-1:0] op_b,
    output logic signed [RND_W-1:0]      rnd_out
);

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_next;
    logic signed [PROD_W-1:0] biased;

    assign prod_next = PROD_W'(op_a) * PROD_W'(op_b);

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg <= prod_next;
        end
    end

    // Half an LSB then arithmetic shift: nearest, ties toward +infinity
    assign biased  = prod_reg + $signed(PROD_W'(32768));
    assign rnd_out = RND_W'(biased >>> 16);

endmodule

`default_nettype wire

// File: src/afc_div.sv
// Serial restoring divider, two quotient bits per cycle, signed and saturated result.
`default_nettype none

module afc_div import afc_pkg::*; (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire afc_div_req_t req,
    output afc_div_rsp_t      rsp
);

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 neg_reg;
    logic [DIV_W-1:0]     dvd_reg;
    logic [15:0]          rem_reg;
    logic [15:0]          dsr_reg;

    logic [DIV_W-1:0]     dvd_next;
    logic [15:0]          rem_next;
    logic [16:0]          rem_sh;
    logic [16:0]          rem_sub;
    logic signed [31:0]   quot_sat;

    // Two restoring steps; quotient bits shift into the dividend LSB
    always_comb begin
        dvd_next = dvd_reg;
        rem_next = rem_reg;
        rem_sh   = '0;
        rem_sub  = '0;
        for (int i = 0; i < 2; i++) begin
            rem_sh   = {rem_next, dvd_next[DIV_W-1]};
            dvd_next = {dvd_next[DIV_W-2:0], 1'b0};
            rem_sub  = rem_sh - {1'b0, dsr_reg};
            if (rem_sh >= {1'b0, dsr_reg}) begin
                rem_next    = rem_sub[15:0];
                dvd_next[0] = 1'b1;
            end else begin
                rem_next = rem_sh[15:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            // Pulse done after the last step
            done_reg <= !req.start && busy_reg && (cnt_reg == '0);
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= DIV_CNT_W'(DIV_STEPS - 1);
                neg_reg  <= req.neg;
                dvd_reg  <= req.mag;
                rem_reg  <= '0;
                dsr_reg  <= req.divisor;
            end else if (busy_reg) begin
                dvd_reg <= dvd_next;
                rem_reg <= rem_next;
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    // Clamp magnitude, then apply sign
    always_comb begin
        if (!neg_reg) begin
            if (|dvd_reg[DIV_W-1:31]) begin
                quot_sat = 32'sh7FFF_FFFF;
            end else begin
                quot_sat = $signed(dvd_reg[31:0]);
            end
        end else begin
            if ((|dvd_reg[DIV_W-1:32]) || (dvd_reg[31] && (|dvd_reg[30:0]))) begin
                quot_sat = 32'sh8000_0000;
            end else begin
                quot_sat = -$signed(dvd_reg[31:0]);
            end
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quot_sat;

endmodule

`default_nettype wire

// File: src/altitude_complementary_filter_top.sv
// Top level of the altitude complementary filter: config, sequencer and filter state.
//
//  channel | dir | handshake           | payload
//  --------+-----+---------------------+------------------------------------------------
//  s_      | in  | s_tvalid / s_tready | tdata: sample_value, time_step; tuser: command
//  m_      | out | m_tvalid / m_tready | tdata: altitude, vertical_speed; tuser: zero_step
//  cfg_    | in  | cfg_wr_en           | cfg_index, cfg_wdata
//
//  An acceleration request runs capture plus three multiply/writeback passes
//  through the one shared multiplier. A barometer request runs capture, seven
//  multiply/writeback passes, one setup state, the serial divider (two quotient
//  bits per cycle) and one output load; with a zero time step the divider is
//  skipped.
//  s_tready is high only while the sequencer is idle. A finished result waits in
//  the output register, so m_tready low stalls only the final load of the next
//  barometer request. Reset (aresetn, synchronous, active low) restores register
//  defaults and clears all filter state.
`default_nettype none

module altitude_complementary_filter_top import afc_pkg::*; (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,

    // Request channel
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [47:0]          s_tdata,   // [31:0] sample_value, [47:32] time_step
    input  wire logic [0:0]           s_tuser,   // [0] command

    // Result channel
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [63:0]               m_tdata,   // [31:0] altitude, [63:32] vertical_speed
    output logic [0:0]                m_tuser,   // [0] zero_step

    // Configuration write port
    input  wire logic                 cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [20:0]          cfg_wdata
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_WB,
        ST_DIV,
        ST_WAIT,
        ST_OUT
    } state_t;

    // Micro-operations: A* for acceleration, B* for barometer
    typedef enum logic [3:0] {
        U_A0, U_A1, U_A2,
        U_B0, U_B1, U_B2, U_B3, U_B4, U_B5, U_B6
    } uop_t;

    // ---------------- configuration registers ----------------
    logic [16:0] decay_alpha_reg;
    logic [16:0] baro_gain_reg;
    logic [20:0] velocity_gain_reg;
    logic [16:0] velocity_decay_reg;
    logic [16:0] accel_deadband_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            decay_alpha_reg    <= 17'd65339;
            baro_gain_reg      <= 17'd131;
            velocity_gain_reg  <= 21'd278528;
            velocity_decay_reg <= 17'd983;
            accel_deadband_reg <= 17'd2621;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_DECAY_ALPHA:    decay_alpha_reg    <= cfg_wdata[16:0];
                CFG_BARO_GAIN:      baro_gain_reg      <= cfg_wdata[16:0];
                CFG_VELOCITY_GAIN:  velocity_gain_reg  <= cfg_wdata;
                CFG_VELOCITY_DECAY: velocity_decay_reg <= cfg_wdata[16:0];
                CFG_ACCEL_DEADBAND: accel_deadband_reg <= cfg_wdata[16:0];
                default: ;  // drop writes to unknown indexes
            endcase
        end
    end

    // ---------------- sequencer and filter state ----------------
    state_t             state_reg;
    uop_t               uop_reg;
    logic signed [31:0] x_reg;
    logic [15:0]        dt_reg;
    logic signed [OPA_W-1:0] t_reg;    // scratch for a rounded partial result
    logic signed [31:0] baro_reg;
    logic signed [31:0] inert_reg;
    logic signed [31:0] vel_reg;
    logic signed [31:0] fused_reg;
    logic signed [31:0] prev_reg;
    logic signed [31:0] speed_reg;
    logic               flag_reg;
    logic               m_tvalid_reg;
    logic [63:0]        m_tdata_reg;
    logic               m_tuser_reg;

    // Shared multiplier
    logic                    mul_en;
    logic signed [OPA_W-1:0] op_a;
    logic signed [OPB_W-1:0] op_b;
    logic signed [RND_W-1:0] rnd;

    afc_mul u_mul (
        .aclk    (aclk),
        .en      (mul_en),
        .op_a    (op_a),
        .op_b    (op_b),
        .rnd_out (rnd)
    );

    // Serial divider for the speed term
    afc_div_req_t div_req;
    afc_div_rsp_t div_rsp;

    afc_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    // Deadband: shrink acceleration toward zero by the threshold
    logic signed [32:0] x_ext;
    logic signed [32:0] x_abs;
    logic signed [32:0] th_ext;
    logic signed [33:0] dead_acc;

    assign x_ext  = {x_reg[31], x_reg};
    assign x_abs  = x_reg[31] ? -x_ext : x_ext;
    assign th_ext = {16'b0, accel_deadband_reg};

    always_comb begin
        if (x_abs < th_ext) begin
            dead_acc = '0;
        end else if (x_reg > 0) begin
            dead_acc = 34'(x_ext) - 34'(th_ext);
        end else begin
            dead_acc = 34'(x_ext) + 34'(th_ext);
        end
    end

    // Operand select per micro-op
    always_comb begin
        case (uop_reg)
            U_A0: begin
                op_a = OPA_W'(dead_acc);
                op_b = $signed(OPB_W'(dt_reg));
            end
            U_A1: begin
                op_a = t_reg;
                op_b = G_Q16;
            end
            U_A2: begin
                op_a = OPA_W'(vel_reg);
                op_b = $signed(OPB_W'(velocity_decay_reg));
            end
            U_B0: begin
                op_a = OPA_W'(baro_reg);
                op_b = $signed(OPB_W'(decay_alpha_reg));
            end
            U_B1: begin
                op_a = OPA_W'(x_reg);
                op_b = $signed(OPB_W'(baro_gain_reg));
            end
            U_B2: begin
                op_a = OPA_W'(vel_reg);
                op_b = $signed(OPB_W'(velocity_gain_reg));
            end
            U_B3: begin
                op_a = t_reg;
                op_b = $signed(OPB_W'(dt_reg));
            end
            U_B4: begin
                op_a = OPA_W'(inert_reg);
                op_b = $signed(OPB_W'(decay_alpha_reg));
            end
            U_B5: begin
                op_a = OPA_W'(inert_reg);
                op_b = W_INERTIAL;
            end
            U_B6: begin
                op_a = OPA_W'(baro_reg);
                op_b = W_BARO;
            end
            default: begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    assign mul_en = (state_reg == ST_MUL);

    // Writeback sums: held scratch plus new product, a state value plus product, or the product alone
    logic signed [SUM_W-1:0] sum_t;
    logic signed [SUM_W-1:0] sum_vel;
    logic signed [31:0]      sat_t;
    logic signed [31:0]      sat_vel;
    logic signed [31:0]      sat_rnd;

    assign sum_t   = SUM_W'(t_reg) + SUM_W'(rnd);
    assign sum_vel = SUM_W'(vel_reg) + SUM_W'(rnd);
    assign sat_t   = sat32(sum_t);
    assign sat_vel = sat32(sum_vel);
    assign sat_rnd = sat32(SUM_W'(rnd));

    // Speed term: fused altitude change, shifted into Q16.16 before dividing
    logic signed [32:0] diff;
    logic        [32:0] diff_mag;

    assign diff     = {fused_reg[31], fused_reg} - {prev_reg[31], prev_reg};
    assign diff_mag = diff[32] ? 33'(-diff) : 33'(diff);

    assign div_req.start   = (state_reg == ST_DIV) && (dt_reg != '0);
    assign div_req.neg     = diff[32];
    assign div_req.mag     = {1'b0, diff_mag, 16'b0};
    assign div_req.divisor = dt_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            uop_reg      <= U_A0;
            baro_reg     <= '0;
            inert_reg    <= '0;
            vel_reg      <= '0;
            fused_reg    <= '0;
            prev_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            // Release a result once taken, unless the next one loads right now
            if (m_tvalid_reg && m_tready && (state_reg != ST_OUT)) begin
                m_tvalid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE: begin
                    // Capture a request and pick its micro-op sequence
                    if (s_tvalid) begin
                        x_reg     <= $signed(s_tdata[31:0]);
                        dt_reg    <= s_tdata[47:32];
                        uop_reg   <= (s_tuser[0] == CMD_ACCEL) ? U_A0 : U_B0;
                        state_reg <= ST_MUL;
                    end
                end

                ST_MUL: begin
                    state_reg <= ST_WB;
                end

                ST_WB: begin
                    case (uop_reg)
                        U_A0: begin
                            t_reg     <= OPA_W'(rnd);
                            uop_reg   <= U_A1;
                            state_reg <= ST_MUL;
                        end
                        U_A1: begin
                            vel_reg   <= sat_vel;
                            uop_reg   <= U_A2;
                            state_reg <= ST_MUL;
                        end
                        U_A2: begin
                            // Velocity decay ends an acceleration request
                            vel_reg   <= sat_rnd;
                            state_reg <= ST_IDLE;
                        end
                        U_B0: begin
                            t_reg     <= OPA_W'(rnd);
                            uop_reg   <= U_B1;
                            state_reg <= ST_MUL;
                        end
                        U_B1: begin
                            baro_reg  <= sat_t;
                            uop_reg   <= U_B2;
                            state_reg <= ST_MUL;
                        end
                        U_B2: begin
                            t_reg     <= OPA_W'(rnd);
                            uop_reg   <= U_B3;
                            state_reg <= ST_MUL;
                        end
                        U_B3: begin
                            t_reg     <= OPA_W'(rnd);
                            uop_reg   <= U_B4;
                            state_reg <= ST_MUL;
                        end
                        U_B4: begin
                            inert_reg <= sat_t;
                            uop_reg   <= U_B5;
                            state_reg <= ST_MUL;
                        end
                        U_B5: begin
                            t_reg     <= OPA_W'(rnd);
                            uop_reg   <= U_B6;
                            state_reg <= ST_MUL;
                        end
                        U_B6: begin
                            fused_reg <= sat_t;
                            state_reg <= ST_DIV;
                        end
                        default: begin
                            state_reg <= ST_IDLE;
                        end
                    endcase
                end

                ST_DIV: begin
                    // Divider starts here unless the time step is zero
                    prev_reg <= fused_reg;
                    if (dt_reg == '0) begin
                        speed_reg <= '0;
                        flag_reg  <= 1'b1;
                        state_reg <= ST_OUT;
                    end else begin
                        flag_reg  <= 1'b0;
                        state_reg <= ST_WAIT;
                    end
                end

                ST_WAIT: begin
                    if (div_rsp.done) begin
                        speed_reg <= div_rsp.quotient;
                        state_reg <= ST_OUT;
                    end
                end

                ST_OUT: begin
                    // Hold until the output register is free
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= {speed_reg, fused_reg};
                        m_tuser_reg  <= flag_reg;
                        state_reg    <= ST_IDLE;
                    end
                end

                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_tready   = (state_reg == ST_IDLE);
    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;
    assign m_tuser[0] = m_tuser_reg;

endmodule

`default_nettype wire

// File: src/afc_checker.sv
// Port-level assertions for the altitude complementary filter, bound to the top level.
`default_nettype none

module afc_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [63:0] m_tdata,
    input wire logic [0:0]  m_tuser
);

    // An accepted request keeps the block busy for at least the next cycle
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("block ready right after accepting a request");

    // A new result only appears after the block was working on a request
    a_result_from_work: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result appeared while the block was idle");

    // Zero time step forces zero speed
    a_zero_step_speed: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |-> (m_tdata[63:32] == 32'd0))
        else $error("zero_step set with nonzero vertical_speed");

    // A stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("stalled result changed or dropped");

endmodule

bind altitude_complementary_filter_top afc_checker u_afc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire
